@@ rtl/mks_pkg.sv @@
`default_nettype none
package mks_pkg;

  localparam int unsigned NUM_IN   = 5;
  localparam int unsigned NUM_OUT  = 8;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned PN_W     = 16;
  localparam int unsigned MN_W     = 24;
  localparam int unsigned LIM_W    = 31;
  localparam int unsigned CFG_W    = 31;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORRECTION_LIMIT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_LIMIT      = 2'd3;

  localparam logic [PN_W-1:0]  PN_RESET  = 16'd262;
  localparam logic [MN_W-1:0]  MN_RESET  = 24'd32768;
  localparam logic [LIM_W-1:0] CL_RESET  = 31'd65536000;
  localparam logic [LIM_W-1:0] ML_RESET  = 31'd3276800;

  typedef struct packed {
    logic load;
    logic kal_start;
    logic div_start;
    logic upd;
    logic fin;
  } mks_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_ch;
    logic first_done;
  } mks_sts_t;

endpackage
`default_nettype wire

@@ rtl/mks_ctrl.sv @@
`default_nettype none
module mks_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_fire_i,
  input  wire logic            out_free_i,
  input  wire mks_pkg::mks_sts_t sts_i,
  output mks_pkg::mks_cmd_t    cmd_o,
  output logic                 busy_o
);
  import mks_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_WAIT, S_UPD, S_FIN, S_HOLD
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: if (in_fire_i) begin
        cmd_o.load = 1'b1;
        state_d = sts_i.first_done ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: if (sts_i.div_done) state_d = S_UPD;
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d = sts_i.last_ch ? S_FIN : S_DIV;
      end
      S_FIN: if (out_free_i) begin
        cmd_o.fin = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
endmodule
`default_nettype wire

@@ rtl/mks_div.sv @@
`default_nettype none
// restoring divider, one quotient bit per cycle; zero divisor gives zero
module mks_div #(
  parameter int unsigned NUM_W = 40,
  parameter int unsigned DEN_W = 26
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quo_o
);
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   rem_q;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q, done_q, zero_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] diff;

  assign trial = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(NUM_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
      zero_q <= (den_i == '0);
    end else if (run_q) begin
      if (!diff[DEN_W+1]) begin
        rem_q <= diff[DEN_W:0];
        quo_q <= {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = zero_q ? '0 : quo_q;
endmodule
`default_nettype wire

@@ rtl/mks_dp.sv @@
`default_nettype none
module mks_dp #(
  parameter int unsigned CHANNELS  = 5,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire mks_pkg::mks_cmd_t                  cmd_i,
  output mks_pkg::mks_sts_t                       sts_o,
  input  wire logic [mks_pkg::NUM_IN*32-1:0]      in_i,
  input  wire logic [mks_pkg::PN_W-1:0]           pn_i,
  input  wire logic [mks_pkg::MN_W-1:0]           mn_i,
  input  wire logic [mks_pkg::LIM_W-1:0]          cl_i,
  input  wire logic [mks_pkg::LIM_W-1:0]          ml_i,
  output logic [mks_pkg::NUM_OUT*32-1:0]          res_o
);
  import mks_pkg::*;

  localparam int unsigned VAR_W = FRAC_BITS + 4;
  localparam int unsigned PRI_W = VAR_W + 1;
  localparam int unsigned DEN_W = PRI_W + 1 > MN_W + 1 ? PRI_W + 1 : MN_W + 1;
  localparam int unsigned NUM_W = PRI_W + FRAC_BITS;
  localparam int unsigned GAIN_W = FRAC_BITS + 1;
  localparam int unsigned CH_W = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
  localparam logic [VAR_W-1:0] ONE_VAR = VAR_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W+1:0] S48_MAX = (SUM_W+2)'((64'sd1 <<< (SUM_W-1)) - 1);
  localparam logic signed [SUM_W+1:0] S48_MIN = -S48_MAX - 1;

  logic signed [SUM_W-1:0] sum_q [CHANNELS];
  logic signed [SUM_W-1:0] est_q [CHANNELS];
  logic [VAR_W-1:0]        var_q [CHANNELS];
  logic                    first_q;
  logic [CH_W-1:0]         ch_q;
  logic signed [FIELD_W-1:0] raw_q [NUM_IN];
  logic [NUM_OUT*32-1:0]   res_q;

  function automatic logic signed [FIELD_W-1:0] sat32(input logic signed [SUM_W+1:0] v);
    logic signed [SUM_W+1:0] hi, lo;
    hi = (SUM_W+2)'(64'sd2147483647);
    lo = -hi - 1;
    if (v > hi) return FIELD_W'(hi);
    if (v < lo) return FIELD_W'(lo);
    return v[FIELD_W-1:0];
  endfunction

  // divider operands for current channel
  logic [PRI_W-1:0] prior;
  logic [DEN_W-1:0] den;
  logic             div_done;
  logic [NUM_W-1:0] quo;
  assign prior = PRI_W'(var_q[ch_q]) + PRI_W'(pn_i);
  assign den   = DEN_W'(prior) + DEN_W'(mn_i);

  mks_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.div_start),
    .num_i({prior, {FRAC_BITS{1'b0}}}),
    .den_i(den),
    .done_o(div_done),
    .quo_o(quo)
  );

  // gain <= 1.0 since prior <= den
  logic [GAIN_W-1:0] gain_q;
  logic              gain_v_q;
  logic signed [SUM_W:0] d;
  logic [SUM_W:0]        m;
  logic [SUM_W+GAIN_W:0] step_hi, step_lo;
  logic [SUM_W:0]        step;
  logic signed [SUM_W+1:0] est_n;
  logic [GAIN_W+PRI_W-1:0] vprod;
  logic [GAIN_W+PRI_W-1:0] vsh;
  logic [VAR_W-1:0]        var_n;

  always_comb begin
    d = (SUM_W+1)'(sum_q[ch_q]) - (SUM_W+1)'(est_q[ch_q]);
    m = d[SUM_W] ? (SUM_W+1)'(-d) : d;
    step_hi = (SUM_W+GAIN_W+1)'(m >> FRAC_BITS) * (SUM_W+GAIN_W+1)'(gain_q);
    step_lo = ((SUM_W+GAIN_W+1)'(m & ((SUM_W+1)'(1) << FRAC_BITS) - (SUM_W+1)'(1))
              * (SUM_W+GAIN_W+1)'(gain_q)) >> FRAC_BITS;
    step = (SUM_W+1)'(step_hi + step_lo);
    est_n = d[SUM_W] ? (SUM_W+2)'(est_q[ch_q]) - (SUM_W+2)'(step)
                     : (SUM_W+2)'(est_q[ch_q]) + (SUM_W+2)'(step);
    if (est_n > S48_MAX) est_n = S48_MAX;
    if (est_n < S48_MIN) est_n = S48_MIN;
    vprod = (GAIN_W+PRI_W)'((GAIN_W)'(ONE_VAR[GAIN_W-1:0]) - gain_q) * (GAIN_W+PRI_W)'(prior);
    vsh = vprod >> FRAC_BITS;
    var_n = (vsh > (GAIN_W+PRI_W)'({VAR_W{1'b1}})) ? {VAR_W{1'b1}} : VAR_W'(vsh);
  end

  // results
  logic signed [SUM_W:0] dfull [NUM_IN];
  logic signed [SUM_W+1:0] fix [3];
  logic all_below;
  always_comb begin
    for (int c = 0; c < NUM_IN; c++) begin
      if (c < CHANNELS)
        dfull[c] = (SUM_W+1)'(est_q[c % CHANNELS]) - (SUM_W+1)'(sum_q[c % CHANNELS]);
      else
        dfull[c] = '0;
    end
    all_below = 1'b1;
    for (int c = 2; c < NUM_IN; c++)
      if (!(dfull[c] < $signed({1'b0, (SUM_W)'(cl_i)}))) all_below = 1'b0;
    for (int c = 0; c < 3; c++) begin
      fix[c] = (SUM_W+2)'(raw_q[c+2]);
      if (all_below) fix[c] = fix[c] + (SUM_W+2)'(dfull[c+2]);
      if ((fix[c] < 0 ? -fix[c] : fix[c]) > $signed({1'b0, (SUM_W+1)'(ml_i)}))
        fix[c] = (SUM_W+2)'(raw_q[c+2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        sum_q[c] <= '0;
        est_q[c] <= '0;
        var_q[c] <= ONE_VAR;
      end
      first_q  <= 1'b0;
      ch_q     <= '0;
      gain_v_q <= 1'b0;
    end else begin
      gain_v_q <= div_done;
      if (cmd_i.load) begin
        ch_q <= '0;
        first_q <= 1'b1;
        for (int c = 0; c < CHANNELS; c++) begin
          logic signed [SUM_W+1:0] s;
          s = (SUM_W+2)'(sum_q[c]);
          if (c < NUM_IN) s = s + (SUM_W+2)'($signed(in_i[(c % NUM_IN)*32 +: 32]));
          if (s > S48_MAX) s = S48_MAX;
          if (s < S48_MIN) s = S48_MIN;
          sum_q[c] <= SUM_W'(s);
        end
      end
      if (cmd_i.upd) begin
        est_q[ch_q] <= SUM_W'(est_n);
        var_q[ch_q] <= var_n;
        ch_q <= ch_q + CH_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_done) gain_q <= GAIN_W'(quo);
    if (cmd_i.load)
      for (int c = 0; c < NUM_IN; c++) raw_q[c] <= in_i[c*32 +: 32];
    if (cmd_i.fin) begin
      for (int c = 0; c < NUM_IN; c++) res_q[c*32 +: 32] <= sat32((SUM_W+2)'(dfull[c]));
      for (int c = 0; c < 3; c++) res_q[(NUM_IN+c)*32 +: 32] <= sat32(fix[c]);
    end
  end

  assign sts_o.div_done   = gain_v_q;
  assign sts_o.last_ch    = (ch_q == CH_W'(CHANNELS - 1));
  assign sts_o.first_done = first_q;
  assign res_o = res_q;
endmodule
`default_nettype wire

@@ rtl/motion_kalman_smoother.sv @@
// channel  dir  width  fields
// s_axis   in   160    tdata: delta_scale_x, delta_scale_y, delta_angle,
//                      delta_shift_x, delta_shift_y
// m_axis   out  256    tdata: diff_scale_x..diff_shift_y, out_angle, out_shift_x,
//                      out_shift_y
// cfg      in   31     process_noise, measurement_noise, correction_limit, motion_limit
// Each item runs the shared bit-serial gain divider once per channel.
// The first item after reset skips the filter.
// Reset is asynchronous; the result register holds one word, and a new item
// is taken while it waits; the next result waits until it is taken.
`default_nettype none
module motion_kalman_smoother #(
  parameter int unsigned CHANNELS  = 5,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [159:0] s_axis_tdata, // delta_scale_x .. delta_shift_y
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [255:0]      m_axis_tdata, // diff_scale_x .. out_shift_y
  input  wire logic         cfg_we_i,
  input  wire logic [mks_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [mks_pkg::CFG_W-1:0]     cfg_data_i
);
  import mks_pkg::*;

  logic [PN_W-1:0]  pn_q;
  logic [MN_W-1:0]  mn_q;
  logic [LIM_W-1:0] cl_q, ml_q;
  logic             ov_q;
  mks_cmd_t         cmd;
  mks_sts_t         sts;
  logic             busy;
  logic             in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pn_q <= PN_RESET;
      mn_q <= MN_RESET;
      cl_q <= CL_RESET;
      ml_q <= ML_RESET;
      ov_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PROCESS_NOISE:     pn_q <= cfg_data_i[PN_W-1:0];
          REG_MEASUREMENT_NOISE: mn_q <= cfg_data_i[MN_W-1:0];
          REG_CORRECTION_LIMIT:  cl_q <= cfg_data_i;
          REG_MOTION_LIMIT:      ml_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd.fin) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
    end
  end

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ov_q;

  mks_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i(in_fire),
    .out_free_i(!ov_q || m_axis_tready),
    .sts_i(sts),
    .cmd_o(cmd),
    .busy_o(busy)
  );

  mks_dp #(.CHANNELS(CHANNELS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd),
    .sts_o(sts),
    .in_i(s_axis_tdata),
    .pn_i(pn_q),
    .mn_i(mn_q),
    .cl_i(cl_q),
    .ml_i(ml_q),
    .res_o(m_axis_tdata)
  );
endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mks_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 6000;
  localparam int unsigned SETTLE_CYCLES  = 300;
  localparam int unsigned PHASE_ITEMS    = 400;

  class kalman_scoreboard;
    localparam longint S48_HI = (64'sd1 <<< 47) - 1;
    localparam longint S48_LO = -(64'sd1 <<< 47);
    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;
    localparam longint ONE_Q  = 64'sd65536;
    localparam longint VAR_HI = (64'sd1 <<< 20) - 1;

    longint traj[5];
    longint est[5];
    longint varc[5];
    bit     primed;
    longint proc_noise, meas_noise, corr_limit, mot_limit;
    logic [255:0] pending[$];
    int errors;

    function new();
      for (int c = 0; c < 5; c++) begin
        traj[c] = 0;
        est[c]  = 0;
        varc[c] = ONE_Q;
      end
      primed     = 0;
      proc_noise = longint'(PN_RESET);
      meas_noise = longint'(MN_RESET);
      corr_limit = longint'(CL_RESET);
      mot_limit  = longint'(ML_RESET);
      errors     = 0;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_PROCESS_NOISE:     proc_noise = longint'(val[PN_W-1:0]);
        REG_MEASUREMENT_NOISE: meas_noise = longint'(val[MN_W-1:0]);
        REG_CORRECTION_LIMIT:  corr_limit = longint'(val[LIM_W-1:0]);
        REG_MOTION_LIMIT:      mot_limit  = longint'(val[LIM_W-1:0]);
        default: ;
      endcase
    endfunction

    function void filter_channel(int c);
      longint prior, denom, gain, d, m, stp, v;
      prior = varc[c] + proc_noise;
      denom = prior + meas_noise;
      gain  = (denom != 0) ? (prior <<< 16) / denom : 0;
      d     = traj[c] - est[c];
      m     = d < 0 ? -d : d;
      stp   = (m >> 16) * gain + (((m & 64'hFFFF) * gain) >> 16);
      est[c] = clip(d < 0 ? est[c] - stp : est[c] + stp, S48_LO, S48_HI);
      v     = ((ONE_Q - gain) * prior) >> 16;
      varc[c] = v > VAR_HI ? VAR_HI : v;
    endfunction

    function void note_input(logic [159:0] w);
      longint raw[5];
      longint diff[5];
      longint fixed_v[3];
      logic [255:0] res;
      for (int c = 0; c < 5; c++) begin
        raw[c]  = longint'($signed(w[32*c +: 32]));
        traj[c] = clip(traj[c] + raw[c], S48_LO, S48_HI);
      end
      if (primed) begin
        for (int c = 0; c < 5; c++) filter_channel(c);
      end else begin
        primed = 1;
      end
      for (int c = 0; c < 5; c++) begin
        diff[c] = est[c] - traj[c];
        res[32*c +: 32] = 32'(clip(diff[c], S32_LO, S32_HI));
      end
      for (int c = 0; c < 3; c++) fixed_v[c] = raw[2+c];
      if (diff[2] < corr_limit && diff[3] < corr_limit && diff[4] < corr_limit) begin
        for (int c = 0; c < 3; c++) fixed_v[c] = raw[2+c] + diff[2+c];
      end
      for (int c = 0; c < 3; c++) begin
        if ((fixed_v[c] < 0 ? -fixed_v[c] : fixed_v[c]) > mot_limit) fixed_v[c] = raw[2+c];
        res[32*(5+c) +: 32] = 32'(clip(fixed_v[c], S32_LO, S32_HI));
      end
      pending.insert(pending.size(), res);
    endfunction

    function void check_output(logic [255:0] w);
      logic [255:0] exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %h", $time, w);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      for (int f = 0; f < 8; f++) begin
        if (w[32*f +: 32] !== exp_w[32*f +: 32]) begin
          $display("%0t: field %0d expected %h actual %h", $time, f,
                   exp_w[32*f +: 32], w[32*f +: 32]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [255:0] m_axis_tdata;
  logic cfg_we_i = 0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_PROCESS_NOISE;
  logic [CFG_W-1:0] cfg_data_i = '0;

  kalman_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  int unsigned stall_mode = 0;
  int unsigned cyc = 0;
  int unsigned burst_left = 0;
  bit gaps_on = 1;

  always #4 clk_i = ~clk_i;

  motion_kalman_smoother u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc % 97 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (cyc % 40) < 8;
      default: m_axis_tready <= ($urandom_range(0, 7) != 0);
    endcase
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_word(logic [159:0] d);
    if (gaps_on && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    s_axis_tdata  <= d;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_all(int unsigned pn, int unsigned mn,
                         int unsigned cl, int unsigned ml);
    drain();
    write_reg(REG_PROCESS_NOISE, CFG_W'(pn));
    write_reg(REG_MEASUREMENT_NOISE, CFG_W'(mn));
    write_reg(REG_CORRECTION_LIMIT, CFG_W'(cl));
    write_reg(REG_MOTION_LIMIT, CFG_W'(ml));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_field(int unsigned kind);
    case (kind)
      0: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      1: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      default: return $urandom();
    endcase
  endfunction

  task automatic random_items(int unsigned n);
    logic [159:0] d;
    int unsigned kind;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 50 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      for (int c = 0; c < 5; c++)
        d[32*c +: 32] = rand_field(kind < 6 ? 0 : (kind < 8 ? 1 : 2));
      push_word(d);
    end
  endtask

  initial begin
    logic [31:0] pats[8];
    pats = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
             32'h1, 32'h55555555, 32'hAAAAAAAA, 32'h00010000};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 8; i++) push_word({5{pats[i]}});
    for (int i = 0; i < 8; i++)
      push_word({pats[i], pats[(i+1)%8], pats[(i+3)%8], pats[(i+5)%8], pats[7-i]});
    for (int i = 0; i < 4; i++) push_word({5{32'h7FFFFFFF}});
    for (int i = 0; i < 4; i++) push_word({5{32'h80000000}});
    random_items(PHASE_ITEMS - 24);

    set_all(0, 1, 0, 0);
    push_word({5{32'h00030000}});
    push_word({5{32'hFFFD0000}});
    random_items(PHASE_ITEMS);

    set_all(32'hFFFF, 32'hFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    random_items(PHASE_ITEMS);

    set_all($urandom_range(0, 65535), $urandom_range(1, 200000),
            $urandom_range(0, 32'h7FFFFFFF), $urandom_range(0, 32'h7FFFFFFF));
    random_items(PHASE_ITEMS / 2);
    set_all(262, 32768, $urandom_range(0, 1 << 20), $urandom_range(0, 1 << 22));
    random_items(PHASE_ITEMS / 2);

    drain();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
rtl/mks_pkg.sv
rtl/mks_ctrl.sv
rtl/mks_div.sv
rtl/mks_dp.sv
rtl/motion_kalman_smoother.sv
verif/tb_top.sv
